// ===== rtl/ufr_pkg.sv =====
// Shared types, codes and the CRC-16/XMODEM byte update for the frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package ufr_pkg;

   localparam logic [7:0]  HEADER_RESET  = 8'hAA;
   localparam logic [7:0]  TAIL_RESET    = 8'h55;
   localparam logic [7:0]  MAX_LEN_RESET = 8'd199;
   localparam logic [7:0]  MIN_LEN       = 8'd7;
   localparam logic [7:0]  OVERHEAD      = 8'd6;
   localparam logic [15:0] CRC_POLY      = 16'h1021;

   typedef enum logic [1:0] {
      CSR_HEADER  = 2'd0,
      CSR_TAIL    = 2'd1,
      CSR_MAX_LEN = 2'd2,
      CSR_NONE    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_LEN  = 3'd1,
      PH_PORT = 3'd2,
      PH_DATA = 3'd3,
      PH_CRCH = 3'd4,
      PH_CRCL = 3'd5,
      PH_TAIL = 3'd6
   } phase_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_BAD_CRC  = 2'd1,
      STATUS_BAD_TAIL = 2'd2
   } status_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] port;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [7:0] payload_length;
      logic [1:0] status;
   } rsp_rec_type;

   typedef struct packed {
      logic       write;
      logic [1:0] index;
      logic [7:0] data;
   } csr_wr_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ufr_parser.sv =====
// Front end: configuration registers, frame state machine, CRC and result records.
`timescale 1ns / 1ps
`default_nettype none
module ufr_parser
   import ufr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire csr_wr_type  csr_wr,
   input  wire logic        byte_valid,
   input  wire logic [7:0]  rx_byte,
   output logic             push,
   output rsp_rec_type      push_rec
);

   logic [7:0]  header_ff, header_in;
   logic [7:0]  tail_ff, tail_in;
   logic [7:0]  max_len_ff, max_len_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  byte_index_ff, byte_index_in;
   logic [7:0]  port_ff, port_in;
   logic [7:0]  length_ff, length_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [15:0] crc_next;
   logic [1:0]  verdict;

   always_comb begin
      header_in  = header_ff;
      tail_in    = tail_ff;
      max_len_in = max_len_ff;
      if (csr_wr.write) begin
         case (csr_index_type'(csr_wr.index))
            CSR_HEADER:  header_in  = csr_wr.data;
            CSR_TAIL:    tail_in    = csr_wr.data;
            CSR_MAX_LEN: max_len_in = csr_wr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= HEADER_RESET;
         tail_ff    <= TAIL_RESET;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         header_ff  <= header_in;
         tail_ff    <= tail_in;
         max_len_ff <= max_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         bytes_left_ff <= '0;
         byte_index_ff <= '0;
         port_ff       <= '0;
         length_ff     <= '0;
         crc_ff        <= '0;
         rx_crc_ff     <= '0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         byte_index_ff <= byte_index_in;
         port_ff       <= port_in;
         length_ff     <= length_in;
         crc_ff        <= crc_in;
         rx_crc_ff     <= rx_crc_in;
      end
   end

   always_comb begin
      crc_next = crc_feed((phase_ff == PH_HUNT) ? 16'h0000 : crc_ff, rx_byte);

      if (rx_byte != tail_ff) begin
         verdict = STATUS_BAD_TAIL;
      end else if (rx_crc_ff != crc_ff) begin
         verdict = STATUS_BAD_CRC;
      end else begin
         verdict = STATUS_GOOD;
      end

      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      byte_index_in = byte_index_ff;
      port_in       = port_ff;
      length_in     = length_ff;
      crc_in        = crc_ff;
      rx_crc_in     = rx_crc_ff;
      push          = 1'b0;

      push_rec.kind           = KIND_PAYLOAD;
      push_rec.port           = port_ff;
      push_rec.payload_byte   = rx_byte;
      push_rec.payload_index  = byte_index_ff;
      push_rec.payload_length = length_ff - OVERHEAD;
      push_rec.status         = STATUS_GOOD;

      if (byte_valid) begin
         case (phase_ff)
            PH_LEN: begin
               if (rx_byte >= MIN_LEN && rx_byte <= max_len_ff) begin
                  length_in     = rx_byte;
                  bytes_left_in = rx_byte - OVERHEAD;
                  byte_index_in = '0;
                  crc_in        = crc_next;
                  phase_in      = PH_PORT;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_PORT: begin
               port_in  = rx_byte;
               crc_in   = crc_next;
               phase_in = PH_DATA;
            end
            PH_DATA: begin
               push          = 1'b1;
               crc_in        = crc_next;
               byte_index_in = byte_index_ff + 8'd1;
               bytes_left_in = bytes_left_ff - 8'd1;
               if (bytes_left_ff == 8'd1) begin
                  phase_in = PH_CRCH;
               end
            end
            PH_CRCH: begin
               rx_crc_in = {rx_byte, 8'h00};
               phase_in  = PH_CRCL;
            end
            PH_CRCL: begin
               rx_crc_in = {rx_crc_ff[15:8], rx_byte};
               phase_in  = PH_TAIL;
            end
            PH_TAIL: begin
               push                   = 1'b1;
               push_rec.kind          = KIND_VERDICT;
               push_rec.payload_byte  = '0;
               push_rec.payload_index = '0;
               push_rec.status        = verdict;
               phase_in               = PH_HUNT;
            end
            default: begin
               if (rx_byte == header_ff) begin
                  crc_in   = crc_next;
                  phase_in = PH_LEN;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ===== rtl/ufr_queue.sv =====
// Back end: result queue that holds records until the receiver takes them.
`timescale 1ns / 1ps
`default_nettype none
module ufr_queue
   import ufr_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rsp_rec_type  push_rec,
   input  wire logic         pop,
   output logic              full,
   output logic              not_empty,
   output rsp_rec_type       head_rec
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rsp_rec_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_rec  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/uart_frame_receiver_crc16.sv =====
// Top level of the framed packet receiver with CRC-16/XMODEM check.
//
// Usage:
//   req_* carries one received byte per item (valid/stall). The block hunts
//   for frames: header, total length L, port, L-6 payload bytes, CRC high,
//   CRC low, tail. Each payload byte yields one rsp_* item (kind 0); the tail
//   byte yields one verdict item (kind 1, status ok / CRC mismatch / bad tail).
//   Other bytes yield no item.
//   csr_* writes header byte (0), tail byte (1) and max frame length (2);
//   csr_ready is always high and other indexes are ignored. Write only while
//   the block is idle.
//   Each result is registered in the queue before it appears on rsp_*.
//   Throughput: one byte per cycle while req_stall is low. The next parser
//   state and one byte-wide CRC update are computed combinationally for each
//   accepted byte; results pass through a QUEUE_DEPTH-entry queue to rsp_*.
//   When the receiver stalls, results collect in the queue; once it is full,
//   req_stall rises until an item leaves.
//   Reset restores the default registers, returns to hunting and empties the
//   queue.
`timescale 1ns / 1ps
`default_nettype none
module uart_frame_receiver_crc16
   import ufr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_port,
   output logic [7:0]       rsp_payload_byte,
   output logic [7:0]       rsp_payload_index,
   output logic [7:0]       rsp_payload_length,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);

   csr_wr_type  csr_wr;
   logic        queue_full;
   logic        push;
   rsp_rec_type push_rec;
   rsp_rec_type head_rec;

   assign csr_ready    = 1'b1;
   assign csr_wr.write = csr_valid && csr_ready;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;
   assign req_stall    = queue_full;

   ufr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .csr_wr     (csr_wr),
      .byte_valid (req_valid && !req_stall),
      .rx_byte    (req_rx_byte),
      .push       (push),
      .push_rec   (push_rec)
   );

   ufr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_rec  (push_rec),
      .pop       (!rsp_stall),
      .full      (queue_full),
      .not_empty (rsp_valid),
      .head_rec  (head_rec)
   );

   assign rsp_kind           = head_rec.kind;
   assign rsp_port           = head_rec.port;
   assign rsp_payload_byte   = head_rec.payload_byte;
   assign rsp_payload_index  = head_rec.payload_index;
   assign rsp_payload_length = head_rec.payload_length;
   assign rsp_status         = head_rec.status;

endmodule
`default_nettype wire

// ===== rtl/ufr_checker.sv =====
// Port-level checks for the frame receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ufr_checker
   import ufr_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_kind,
   input wire logic [7:0] rsp_port,
   input wire logic [7:0] rsp_payload_byte,
   input wire logic [7:0] rsp_payload_index,
   input wire logic [7:0] rsp_payload_length,
   input wire logic [1:0] rsp_status
);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_port)
         && $stable(rsp_payload_byte) && $stable(rsp_payload_index)
         && $stable(rsp_payload_length) && $stable(rsp_status))
      else $error("stalled result changed");

   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_PAYLOAD |->
         rsp_status == STATUS_GOOD && rsp_payload_index < rsp_payload_length)
      else $error("payload item with bad status or index");

   a_verdict_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_VERDICT |->
         rsp_payload_byte == 8'd0 && rsp_payload_index == 8'd0
         && rsp_status != 2'd3 && rsp_payload_length != 8'd0)
      else $error("malformed verdict item");

endmodule

bind uart_frame_receiver_crc16 ufr_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_kind           (rsp_kind),
   .rsp_port           (rsp_port),
   .rsp_payload_byte   (rsp_payload_byte),
   .rsp_payload_index  (rsp_payload_index),
   .rsp_payload_length (rsp_payload_length),
   .rsp_status         (rsp_status)
);
`default_nettype wire
